### hw/rtl/lsg_pkg.sv
package lsg_pkg;

	// Field widths.
	localparam int unsigned TEMP_W    = 16;
	localparam int unsigned LIMIT_W   = 12;
	localparam int unsigned CFG_IDX_W = 2;

	// Drift window: the oldest OLD_HALF samples against the newest NEW_HALF.
	localparam int unsigned WINDOW_LEN = 15;
	localparam int unsigned OLD_HALF   = WINDOW_LEN / 2;
	localparam int unsigned NEW_HALF   = WINDOW_LEN - OLD_HALF;
	localparam int unsigned FILL_W     = $clog2(WINDOW_LEN + 1);

	// Downstream value scaled by OLD_HALF, prepared by the front.
	localparam int unsigned X7_W    = TEMP_W + $clog2(OLD_HALF + 1);
	// Drift limit scaled by OLD_HALF * NEW_HALF.
	localparam int unsigned LIM56_W = LIMIT_W + $clog2(OLD_HALF * NEW_HALF + 1);
	// Signed accumulator for OLD_HALF * new_sum - NEW_HALF * old_sum.
	localparam int unsigned DRIFT_W = 24;

	// Sensor band, exclusive on both ends, and the held value after reset.
	localparam logic [TEMP_W-1:0] TEMP_LOW_EXCL  = 16'd1280;
	localparam logic [TEMP_W-1:0] TEMP_HIGH_EXCL = 16'd15360;
	localparam logic [TEMP_W-1:0] HOLD_RESET     = 16'd5120;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] DRIFT_LIM_RESET = 12'd26;
	localparam logic [LIMIT_W-1:0] AGREE_LIM_RESET = 12'd256;
	localparam logic [LIMIT_W-1:0] TIMEOUT_RESET   = 12'd420;

	// Depth of both queues.
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIFT_LIMIT   = 2'd0,
		CFG_AGREE_LIMIT   = 2'd1,
		CFG_TIMEOUT_TICKS = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_WAIT     = 2'd0,
		ST_SETTLED  = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_ABORTED  = 2'd3
	} status_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic              abort;
		logic              agree_ok;
		logic [TEMP_W-1:0] held_down;
		logic [TEMP_W-1:0] held_up;
		logic [X7_W-1:0]   down_x7;
	} lsg_work_t;

	typedef struct packed {
		status_t           status;
		logic [TEMP_W-1:0] held_down;
		logic [TEMP_W-1:0] held_up;
	} lsg_result_t;

endpackage

### hw/rtl/lsg_queue.sv
module lsg_queue #(
	parameter int unsigned WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import lsg_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hw/rtl/lsg_front.sv
module lsg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [lsg_pkg::TEMP_W-1:0]     down_temp,
	input  logic [lsg_pkg::TEMP_W-1:0]     up_temp,
	input  logic                           abort,
	input  logic [lsg_pkg::LIMIT_W-1:0]    agree_limit,
	output lsg_pkg::lsg_work_t             item
);
	import lsg_pkg::*;

	logic [TEMP_W-1:0] last_down_q;
	logic [TEMP_W-1:0] last_up_q;
	logic [TEMP_W-1:0] held_down;
	logic [TEMP_W-1:0] held_up;
	logic [TEMP_W-1:0] gap;
	logic              down_in_band;
	logic              up_in_band;

	assign down_in_band = (down_temp > TEMP_LOW_EXCL) && (down_temp < TEMP_HIGH_EXCL);
	assign up_in_band   = (up_temp > TEMP_LOW_EXCL) && (up_temp < TEMP_HIGH_EXCL);

	// An aborted item leaves the held values alone.
	assign held_down = (!abort && down_in_band) ? down_temp : last_down_q;
	assign held_up   = (!abort && up_in_band) ? up_temp : last_up_q;
	assign gap       = (held_down > held_up) ? held_down - held_up : held_up - held_down;

	always_comb begin
		item.abort     = abort;
		item.agree_ok  = (gap <= {{(TEMP_W - LIMIT_W){1'b0}}, agree_limit});
		item.held_down = held_down;
		item.held_up   = held_up;
		item.down_x7   = X7_W'(OLD_HALF) * {{(X7_W - TEMP_W){1'b0}}, held_down};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_down_q <= HOLD_RESET;
			last_up_q   <= HOLD_RESET;
		end else if (take) begin
			last_down_q <= held_down;
			last_up_q   <= held_up;
		end
	end

endmodule

### hw/rtl/lsg_back.sv
module lsg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  lsg_pkg::lsg_work_t             in_item,
	output logic                           in_take,
	input  logic                           out_full,
	output logic                           out_push,
	output lsg_pkg::lsg_result_t           out_item,
	input  logic [lsg_pkg::LIMIT_W-1:0]    timeout_ticks,
	input  logic [lsg_pkg::LIM56_W-1:0]    drift_lim56
);
	import lsg_pkg::*;

	// Shift line of held downstream samples, newest at index 0.
	logic [TEMP_W-1:0]  win_q [WINDOW_LEN];
	logic [FILL_W-1:0]  fill_q;
	logic [LIMIT_W-1:0] tick_q;
	logic [DRIFT_W-1:0] drift_q;

	logic               leave_new_ok;
	logic               leave_old_ok;
	logic [DRIFT_W-1:0] x7_e;
	logic [DRIFT_W-1:0] leave_new_e;
	logic [DRIFT_W-1:0] leave_old_e;
	logic [DRIFT_W-1:0] drift_next;
	logic [DRIFT_W-1:0] drift_mag;
	logic [FILL_W-1:0]  fill_next;
	logic [LIMIT_W-1:0] tick_next;
	logic               drift_ok;
	logic               run_full;
	status_t            status;

	// The sample leaving the newest half moves into the oldest half; the one
	// leaving the oldest half drops out of the window. Both count only once
	// the current run has written that far.
	assign leave_new_ok = (fill_q >= FILL_W'(NEW_HALF));
	assign leave_old_ok = (fill_q == FILL_W'(WINDOW_LEN));
	assign x7_e         = {{(DRIFT_W - X7_W){1'b0}}, in_item.down_x7};
	assign leave_new_e  = leave_new_ok ?
		{{(DRIFT_W - TEMP_W){1'b0}}, win_q[NEW_HALF-1]} : '0;
	assign leave_old_e  = leave_old_ok ?
		{{(DRIFT_W - TEMP_W){1'b0}}, win_q[WINDOW_LEN-1]} : '0;

	// Two's complement running value of OLD_HALF*new_sum - NEW_HALF*old_sum.
	assign drift_next = drift_q + x7_e - DRIFT_W'(WINDOW_LEN) * leave_new_e
		+ DRIFT_W'(NEW_HALF) * leave_old_e;
	assign drift_mag  = drift_next[DRIFT_W-1] ? (~drift_next + 1'b1) : drift_next;
	assign drift_ok   = (drift_mag <= {{(DRIFT_W - LIM56_W){1'b0}}, drift_lim56});

	assign fill_next = leave_old_ok ? fill_q : fill_q + 1'b1;
	assign run_full  = (fill_next == FILL_W'(WINDOW_LEN));
	assign tick_next = (tick_q == '1) ? tick_q : tick_q + 1'b1;

	always_comb begin
		if (in_item.abort) begin
			status = ST_ABORTED;
		end else if (run_full && drift_ok && in_item.agree_ok) begin
			status = ST_SETTLED;
		end else if (tick_next >= timeout_ticks) begin
			status = ST_TIMEOUT;
		end else begin
			status = ST_WAIT;
		end
	end

	assign in_take  = in_valid && !out_full;
	assign out_push = in_take;

	always_comb begin
		out_item.status    = status;
		out_item.held_down = in_item.held_down;
		out_item.held_up   = in_item.held_up;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			tick_q  <= '0;
			drift_q <= '0;
		end else if (in_take) begin
			if (status != ST_WAIT) begin
				fill_q  <= '0;
				tick_q  <= '0;
				drift_q <= '0;
			end else begin
				fill_q  <= fill_next;
				tick_q  <= tick_next;
				drift_q <= drift_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && !in_item.abort) begin
			win_q[0] <= in_item.held_down;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

`ifndef ASSERT_OFF
	a_settle_needs_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.status == ST_SETTLED |-> in_item.agree_ok && run_full)
		else $error("settled result without agreement or a full window");

	a_abort_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && in_item.abort |-> out_item.status == ST_ABORTED)
		else $error("aborted item reported with another status");

	a_outcome_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.status != ST_WAIT
		|=> fill_q == '0 && tick_q == '0 && drift_q == '0)
		else $error("run not cleared after an outcome");

	a_drift_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> drift_q == '0)
		else $error("drift accumulator nonzero with an empty run");
`endif

endmodule

### hw/rtl/loop_settle_gate.sv
// Coolant loop settle gate. Each item pushed is one sensor tick carrying a
// downstream and an upstream temperature (unsigned, 1/256 degC) and an abort
// flag, and each item yields exactly one result, in order: a status (0 waiting,
// 1 settled, 2 timeout, 3 aborted) plus both held temperatures. A reading
// outside the open band 5..60 degC is replaced by the last good value of that
// sensor. Once the run holds 15 samples, the run is settled when the mean of
// the newest 8 held downstream samples and the mean of the oldest 7 differ by
// at most drift_limit and the two sensors agree within agree_limit; otherwise
// it times out after timeout_ticks samples. Any outcome starts a new run, and
// the held values survive. The block takes one item per clock while the item
// queue is not full: a front stage cleans and classifies each item, a two-entry
// queue hands it to the back stage, which keeps the 15-sample shift line and a
// running drift sum updated per item, and a two-entry result queue decouples
// the consumer. A result reaches the result queue through the item queue and
// the back stage. Registers are written through the cfg channel,
// which is always ready; write them only while no item is in flight.
module loop_settle_gate (
	input  logic                             clk,
	input  logic                             arst_n,
	// Item input.
	input  logic                             push,
	output logic                             full,
	input  logic [lsg_pkg::TEMP_W-1:0]       down_temp,
	input  logic [lsg_pkg::TEMP_W-1:0]       up_temp,
	input  logic                             abort,
	// Result output.
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       status,
	output logic [lsg_pkg::TEMP_W-1:0]       held_down,
	output logic [lsg_pkg::TEMP_W-1:0]       held_up,
	// Register writes.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsg_pkg::LIMIT_W-1:0]      cfg_data
);
	import lsg_pkg::*;

	logic [LIMIT_W-1:0] agree_limit_q;
	logic [LIMIT_W-1:0] timeout_ticks_q;
	// The drift limit is kept pre-scaled, so the back stage compares directly.
	logic [LIM56_W-1:0] drift_lim56_q;

	logic        item_take;
	lsg_work_t   front_item;
	lsg_work_t   mid_item;
	logic        mid_full;
	logic        mid_empty;
	logic        mid_pop;
	logic        res_full;
	logic        res_push;
	lsg_result_t res_wdata;
	lsg_result_t res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_lim56_q   <= LIM56_W'(OLD_HALF * NEW_HALF) *
				{{(LIM56_W - LIMIT_W){1'b0}}, DRIFT_LIM_RESET};
			agree_limit_q   <= AGREE_LIM_RESET;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_DRIFT_LIMIT: begin
					drift_lim56_q <= LIM56_W'(OLD_HALF * NEW_HALF) *
						{{(LIM56_W - LIMIT_W){1'b0}}, cfg_data};
				end
				CFG_AGREE_LIMIT: begin
					agree_limit_q <= cfg_data;
				end
				CFG_TIMEOUT_TICKS: begin
					timeout_ticks_q <= cfg_data;
				end
				default: begin
					// Writes to an unused index are dropped.
				end
			endcase
		end
	end

	assign full      = mid_full;
	assign item_take = push && !mid_full;

	lsg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (item_take),
		.down_temp   (down_temp),
		.up_temp     (up_temp),
		.abort       (abort),
		.agree_limit (agree_limit_q),
		.item        (front_item)
	);

	lsg_queue #(
		.WIDTH ($bits(lsg_work_t))
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_take),
		.wdata  (front_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	lsg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (!mid_empty),
		.in_item       (mid_item),
		.in_take       (mid_pop),
		.out_full      (res_full),
		.out_push      (res_push),
		.out_item      (res_wdata),
		.timeout_ticks (timeout_ticks_q),
		.drift_lim56   (drift_lim56_q)
	);

	lsg_queue #(
		.WIDTH ($bits(lsg_result_t))
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign status    = res_head.status;
	assign held_down = res_head.held_down;
	assign held_up   = res_head.held_up;

endmodule
